[design/sae_pkg.sv]
package sae_pkg;

  localparam int VALUE_W  = 32;
  localparam int DEPTH_W  = 9;
  localparam int OP_W     = 3;
  localparam int STATUS_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_RET  = 3'd0,
    OP_PUSH = 3'd1,
    OP_NEG  = 3'd2,
    OP_ADD  = 3'd3,
    OP_SUB  = 3'd4,
    OP_MUL  = 3'd5,
    OP_DIV  = 3'd6
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_RETURN    = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_DIVZERO   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_CALC,
    S_FINISH
  } state_t;

  typedef enum logic [2:0] {
    A_IDLE,
    A_ROUND,
    A_DIV,
    A_SIGN,
    A_SAT
  } alu_state_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef enum logic [1:0] {
    TOP_KEEP,
    TOP_CONST,
    TOP_MEM,
    TOP_ALU
  } top_sel_t;

  typedef struct packed {
    logic in_valid;
    op_t  op;
    logic empty;
    logic single;
    logic full;
    logic divisor_zero;
    logic alu_done;
    logic out_free;
  } ctrl_in_t;

  typedef struct packed {
    logic     in_ready;
    logic     alu_start;
    alu_op_t  alu_op;
    logic     zero_a;
    logic     mem_we;
    top_sel_t top_sel;
    logic     sp_inc;
    logic     sp_dec;
    logic     status_load;
    status_t  status;
    logic     ret_load;
    logic     out_load;
  } ctrl_out_t;

endpackage

[design/sae_if.sv]
interface sae_in_if;
  logic                                valid;
  logic                                ready;
  logic [sae_pkg::OP_W-1:0]            operation;
  logic signed [sae_pkg::VALUE_W-1:0]  constant_value;

  modport source (output valid, output operation, output constant_value, input ready);
  modport sink (input valid, input operation, input constant_value, output ready);
endinterface

interface sae_out_if;
  logic                                valid;
  logic                                ready;
  logic [sae_pkg::STATUS_W-1:0]        status;
  logic signed [sae_pkg::VALUE_W-1:0]  result_value;
  logic [sae_pkg::DEPTH_W-1:0]         stack_depth;

  modport source (output valid, output status, output result_value, output stack_depth,
                  input ready);
  modport sink (input valid, input status, input result_value, input stack_depth,
                output ready);
endinterface

[design/sae_mem.sv]
module sae_mem #(
  parameter int DEPTH = 256
) (
  input  logic                               clk,
  input  logic                               we,
  input  logic [$clog2(DEPTH)-1:0]           waddr,
  input  logic [sae_pkg::VALUE_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0]           raddr,
  output logic [sae_pkg::VALUE_W-1:0]        rdata
);

  logic [sae_pkg::VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[design/sae_alu.sv]
module sae_alu #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  sae_pkg::alu_op_t                   op,
  input  logic signed [sae_pkg::VALUE_W-1:0] a,
  input  logic signed [sae_pkg::VALUE_W-1:0] b,
  output logic                               done,
  output logic signed [sae_pkg::VALUE_W-1:0] result
);

  localparam int VW    = sae_pkg::VALUE_W;
  localparam int ACC_W = 2 * VW;
  localparam int NW    = VW + FRACTION_BITS;
  localparam int CW    = $clog2(NW);
  localparam logic signed [ACC_W-1:0] HALF = (ACC_W'(1) << FRACTION_BITS) >> 1;
  localparam logic signed [ACC_W-1:0] VMAX = $signed({{(ACC_W-VW+1){1'b0}}, {(VW-1){1'b1}}});
  localparam logic signed [ACC_W-1:0] VMIN = $signed({{(ACC_W-VW+1){1'b1}}, {(VW-1){1'b0}}});
  localparam logic [CW-1:0] LAST = CW'(NW - 1);

  sae_pkg::alu_state_t state, state_next;

  logic signed [ACC_W-1:0] acc;
  logic [NW-1:0]           dvd;
  logic [VW-1:0]           rem;
  logic [VW-1:0]           dsr;
  logic                    neg;
  logic [CW-1:0]           cnt;

  logic signed [VW:0]      sum;
  logic signed [ACC_W-1:0] prod;
  logic [VW-1:0]           a_mag;
  logic [VW-1:0]           b_mag;
  logic [VW:0]             trial;
  logic                    ge;
  logic [VW:0]             diff;

  assign sum   = (op == sae_pkg::ALU_SUB) ? ({a[VW-1], a} - {b[VW-1], b})
                                          : ({a[VW-1], a} + {b[VW-1], b});
  assign prod  = a * b;
  assign a_mag = a[VW-1] ? VW'(-a) : VW'(a);
  assign b_mag = b[VW-1] ? VW'(-b) : VW'(b);
  assign trial = {rem, dvd[NW-1]};
  assign ge    = trial >= {1'b0, dsr};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sae_pkg::A_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sae_pkg::A_IDLE: begin
        if (start) begin
          case (op)
            sae_pkg::ALU_MUL: state_next = sae_pkg::A_ROUND;
            sae_pkg::ALU_DIV: state_next = sae_pkg::A_DIV;
            default:          state_next = sae_pkg::A_SAT;
          endcase
        end
      end
      sae_pkg::A_ROUND: state_next = sae_pkg::A_SAT;
      sae_pkg::A_DIV: begin
        if (cnt == LAST) begin
          state_next = sae_pkg::A_SIGN;
        end
      end
      sae_pkg::A_SIGN: state_next = sae_pkg::A_SAT;
      sae_pkg::A_SAT:  state_next = sae_pkg::A_IDLE;
      default:         state_next = sae_pkg::A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      sae_pkg::A_IDLE: begin
        if (start) begin
          case (op)
            sae_pkg::ALU_MUL: acc <= prod;
            sae_pkg::ALU_DIV: begin
              dvd <= NW'(a_mag) << FRACTION_BITS;
              dsr <= b_mag;
              rem <= '0;
              neg <= a[VW-1] ^ b[VW-1];
              cnt <= '0;
            end
            default: acc <= ACC_W'(sum);
          endcase
        end
      end
      sae_pkg::A_ROUND: acc <= (acc + HALF) >>> FRACTION_BITS;
      sae_pkg::A_DIV: begin
        rem <= ge ? diff[VW-1:0] : trial[VW-1:0];
        dvd <= {dvd[NW-2:0], ge};
        cnt <= cnt + CW'(1);
      end
      sae_pkg::A_SIGN: acc <= neg ? -$signed(ACC_W'(dvd)) : $signed(ACC_W'(dvd));
      default: ;
    endcase
  end

  always_comb begin
    done = (state == sae_pkg::A_SAT);
    if (acc > VMAX) begin
      result = VMAX[VW-1:0];
    end else if (acc < VMIN) begin
      result = VMIN[VW-1:0];
    end else begin
      result = acc[VW-1:0];
    end
  end

endmodule

[design/sae_ctrl.sv]
module sae_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  sae_pkg::ctrl_in_t  stat,
  output sae_pkg::ctrl_out_t ctl
);

  sae_pkg::state_t  state, state_next;
  sae_pkg::status_t dec_status;
  sae_pkg::alu_op_t dec_alu_op;
  logic             dec_go_alu;
  logic             dec_zero_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sae_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // instruction decode and fault checks
  always_comb begin
    dec_status = sae_pkg::ST_OK;
    dec_alu_op = sae_pkg::ALU_ADD;
    dec_go_alu = 1'b0;
    dec_zero_a = 1'b0;
    case (stat.op)
      sae_pkg::OP_RET: begin
        dec_status = stat.empty ? sae_pkg::ST_UNDERFLOW : sae_pkg::ST_RETURN;
      end
      sae_pkg::OP_PUSH: begin
        dec_status = stat.full ? sae_pkg::ST_OVERFLOW : sae_pkg::ST_OK;
      end
      sae_pkg::OP_NEG: begin
        dec_status = stat.empty ? sae_pkg::ST_UNDERFLOW : sae_pkg::ST_OK;
        dec_go_alu = !stat.empty;
        dec_alu_op = sae_pkg::ALU_SUB;
        dec_zero_a = 1'b1;
      end
      sae_pkg::OP_ADD, sae_pkg::OP_SUB, sae_pkg::OP_MUL: begin
        dec_status = stat.single ? sae_pkg::ST_UNDERFLOW : sae_pkg::ST_OK;
        dec_go_alu = !stat.single;
        case (stat.op)
          sae_pkg::OP_SUB: dec_alu_op = sae_pkg::ALU_SUB;
          sae_pkg::OP_MUL: dec_alu_op = sae_pkg::ALU_MUL;
          default:         dec_alu_op = sae_pkg::ALU_ADD;
        endcase
      end
      sae_pkg::OP_DIV: begin
        if (stat.single) begin
          dec_status = sae_pkg::ST_UNDERFLOW;
        end else if (stat.divisor_zero) begin
          dec_status = sae_pkg::ST_DIVZERO;
        end else begin
          dec_go_alu = 1'b1;
        end
        dec_alu_op = sae_pkg::ALU_DIV;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      sae_pkg::S_IDLE: begin
        if (stat.in_valid) begin
          state_next = sae_pkg::S_EXEC;
        end
      end
      sae_pkg::S_EXEC: state_next = dec_go_alu ? sae_pkg::S_CALC : sae_pkg::S_FINISH;
      sae_pkg::S_CALC: begin
        if (stat.alu_done) begin
          state_next = sae_pkg::S_FINISH;
        end
      end
      sae_pkg::S_FINISH: begin
        if (stat.out_free) begin
          state_next = sae_pkg::S_IDLE;
        end
      end
      default: state_next = sae_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl             = '0;
    ctl.alu_op      = dec_alu_op;
    ctl.zero_a      = dec_zero_a;
    ctl.top_sel     = sae_pkg::TOP_KEEP;
    ctl.status      = dec_status;
    case (state)
      sae_pkg::S_IDLE: ctl.in_ready = 1'b1;
      sae_pkg::S_EXEC: begin
        ctl.status_load = 1'b1;
        ctl.alu_start   = dec_go_alu;
        if (dec_status == sae_pkg::ST_RETURN) begin
          ctl.ret_load = 1'b1;
          ctl.top_sel  = sae_pkg::TOP_MEM;
          ctl.sp_dec   = 1'b1;
        end else if (stat.op == sae_pkg::OP_PUSH && dec_status == sae_pkg::ST_OK) begin
          ctl.top_sel = sae_pkg::TOP_CONST;
          ctl.sp_inc  = 1'b1;
          ctl.mem_we  = !stat.empty;
        end
      end
      sae_pkg::S_CALC: begin
        if (stat.alu_done) begin
          ctl.top_sel = sae_pkg::TOP_ALU;
          ctl.sp_dec  = (stat.op != sae_pkg::OP_NEG);
        end
      end
      sae_pkg::S_FINISH: ctl.out_load = stat.out_free;
      default: ;
    endcase
  end

endmodule

[design/stack_arithmetic_executor.sv]
// stack machine executing one Q16.16 arithmetic instruction per item
//
// instr channel: operation and constant_value, taken when valid and ready are
// both high; ready is high only while the block is idle. result channel: one
// item per instruction with status, result_value and stack_depth, held in an
// output register until taken.
//
// the top of stack lives in a register, the entries below it in a
// single-port-write memory with a registered read port; the entry under the
// top is read ahead while idle. one shared arithmetic unit does negate, add,
// subtract, multiply and divide.
// push, return, faults and unknown codes go from execute straight to finish;
// negate, add, subtract, multiply and divide first run in the shared unit
// (a rounding step for multiply, one quotient bit per cycle for divide). the
// next instruction can be taken in the cycle after the result is loaded.
// reset empties the stack and clears all control state; the stack memory is
// not cleared. if the receiver stalls, the finished result waits in the
// output register and the next instruction can still be accepted and run;
// its own result waits until the output register frees.
module stack_arithmetic_executor #(
  parameter int STACK_DEPTH   = 256,
  parameter int FRACTION_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  sae_in_if.sink     instr,
  sae_out_if.source  result
);

  localparam int VW  = sae_pkg::VALUE_W;
  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  sae_pkg::ctrl_in_t  stat;
  sae_pkg::ctrl_out_t ctl;

  logic [SPW-1:0]        sp;
  logic signed [VW-1:0]  top;
  logic signed [VW-1:0]  konst;
  logic signed [VW-1:0]  ret_val;
  sae_pkg::op_t          op;
  sae_pkg::status_t      status;

  logic [AW-1:0]         raddr;
  logic [AW-1:0]         waddr;
  logic [VW-1:0]         rdata;
  logic signed [VW-1:0]  alu_a;
  logic                  alu_done;
  logic signed [VW-1:0]  alu_result;
  logic                  out_free;
  logic signed [VW-1:0]  out_value;

  assign raddr    = AW'(sp - SPW'(2));
  assign waddr    = AW'(sp - SPW'(1));
  assign alu_a    = ctl.zero_a ? '0 : $signed(rdata);
  assign out_free = !result.valid || result.ready;

  assign stat.in_valid     = instr.valid;
  assign stat.op           = op;
  assign stat.empty        = (sp == '0);
  assign stat.single       = (sp < SPW'(2));
  assign stat.full         = (sp == SPW'(STACK_DEPTH));
  assign stat.divisor_zero = (top == '0);
  assign stat.alu_done     = alu_done;
  assign stat.out_free     = out_free;

  assign instr.ready = ctl.in_ready;

  sae_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  sae_mem #(
    .DEPTH (STACK_DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (ctl.mem_we),
    .waddr (waddr),
    .wdata (top),
    .raddr (raddr),
    .rdata (rdata)
  );

  sae_alu #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_alu (
    .clk    (clk),
    .rst    (rst),
    .start  (ctl.alu_start),
    .op     (ctl.alu_op),
    .a      (alu_a),
    .b      (top),
    .done   (alu_done),
    .result (alu_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else if (ctl.sp_inc) begin
      sp <= sp + SPW'(1);
    end else if (ctl.sp_dec) begin
      sp <= sp - SPW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (instr.valid && instr.ready) begin
      op    <= sae_pkg::op_t'(instr.operation);
      konst <= instr.constant_value;
    end
    if (ctl.status_load) begin
      status <= ctl.status;
    end
    if (ctl.ret_load) begin
      ret_val <= top;
    end
    case (ctl.top_sel)
      sae_pkg::TOP_CONST: top <= konst;
      sae_pkg::TOP_MEM:   top <= $signed(rdata);
      sae_pkg::TOP_ALU:   top <= alu_result;
      default: ;
    endcase
  end

  always_comb begin
    if (status == sae_pkg::ST_RETURN) begin
      out_value = ret_val;
    end else if (sp == '0) begin
      out_value = '0;
    end else begin
      out_value = top;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (ctl.out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      result.status       <= status;
      result.result_value <= out_value;
      result.stack_depth  <= sae_pkg::DEPTH_W'(sp);
    end
  end

  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= SPW'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    instr.valid && instr.ready |=> !instr.ready)
    else $error("ready while an item is in progress");

  a_sp_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (sp == $past(sp) || sp == $past(sp) + SPW'(1)
                     || sp == $past(sp) - SPW'(1)))
    else $error("stack pointer moved by more than one");

  a_underflow_depth: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load && status == sae_pkg::ST_UNDERFLOW |-> sp < SPW'(2))
    else $error("underflow reported with two or more values");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load && status == sae_pkg::ST_OVERFLOW |-> sp == SPW'(STACK_DEPTH))
    else $error("overflow reported on a stack that is not full");

endmodule
